>>> hdl/ctlru_pkg.sv
// Package for the cache tag timing block: field widths, register codes,
// reset values and the command and status structs between controller and datapath.
// No dependencies.
package ctlru_pkg;

   // Widths of the request and response fields.
   localparam int ADDR_W = 32;
   localparam int BC_W = 7;
   localparam int CYC_W = 48;
   localparam int DL_W = 16;
   localparam int LAT_W = 32;
   localparam int MISS_W = 2;
   // Internal ready cycle holds sums that can pass the 48-bit cycle range.
   localparam int RDY_W = 50;

   // Configuration port.
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_HIT_LATENCY = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MISS_PENALTY = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REFILL_CYCLES = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STORE_DRAIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SB_ENTRIES = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_ALLOC = 3'd5;

   localparam logic [7:0] HIT_LATENCY_RST = 8'd1;
   localparam logic [7:0] MISS_PENALTY_RST = 8'd0;
   localparam logic [7:0] REFILL_CYCLES_RST = 8'd8;
   localparam logic [7:0] STORE_DRAIN_RST = 8'd1;
   localparam logic [4:0] SB_ENTRIES_RST = 5'd4;
   localparam logic [4:0] SB_ENTRIES_MAX = 5'd16;

   localparam logic [CYC_W-1:0] CYC_MAX = {CYC_W{1'b1}};

   // Default geometry.
   localparam int OFFS_BITS_DEF = 6;
   localparam int SETS_DEF = 64;
   localparam int WAYS_DEF = 4;
   localparam int MAX_ACCESS_BYTES_DEF = 64;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clr;
      logic latch;
      logic rd;
      logic check;
      logic scan;
      logic wr;
      logic skip;
      logic next;
      logic st;
      logic fin;
      logic out;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clr_last;
      logic hit;
      logic alloc;
      logic scan_need;
      logic scan_last;
      logic line_last;
      logic is_store;
   } status_type;

endpackage

>>> hdl/ctlru_ctrl.sv
// Controller state machine of the cache tag timing block.
// Depends on ctlru_pkg for the command and status structs.
module ctlru_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ctlru_pkg::status_type status,
   output ctlru_pkg::cmd_type    cmd
);

   localparam logic [3:0] S_CLR  = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_RD   = 4'd2;
   localparam logic [3:0] S_CK   = 4'd3;
   localparam logic [3:0] S_SC   = 4'd4;
   localparam logic [3:0] S_WR   = 4'd5;
   localparam logic [3:0] S_ST   = 4'd6;
   localparam logic [3:0] S_FN   = 4'd7;
   localparam logic [3:0] S_OUT  = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic [3:0] post_state;

   // After the last line, stores go through the drain step.
   assign post_state = status.is_store ? S_ST : S_OUT;
   assign busy = (state_ff != S_IDLE);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_CLR: begin
            cmd.clr = 1'b1;
            if (status.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in = S_RD;
            end
         end
         S_RD: begin
            cmd.rd = 1'b1;
            state_in = S_CK;
         end
         S_CK: begin
            cmd.check = 1'b1;
            if (status.hit) begin
               state_in = S_WR;
            end else if (!status.alloc) begin
               cmd.skip = 1'b1;
               if (status.line_last) begin
                  state_in = post_state;
               end else begin
                  cmd.next = 1'b1;
                  state_in = S_RD;
               end
            end else if (status.scan_need) begin
               state_in = S_SC;
            end else begin
               state_in = S_WR;
            end
         end
         S_SC: begin
            cmd.scan = 1'b1;
            if (status.scan_last) state_in = S_WR;
         end
         S_WR: begin
            cmd.wr = 1'b1;
            if (status.line_last) begin
               state_in = post_state;
            end else begin
               cmd.next = 1'b1;
               state_in = S_RD;
            end
         end
         S_ST: begin
            cmd.st = 1'b1;
            state_in = S_FN;
         end
         S_FN: begin
            cmd.fin = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            cmd.out = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register; reset starts the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hdl/ctlru_dp.sv
// Datapath of the cache tag timing block: configuration registers, tag, stamp
// and ready memories, port queue and latency arithmetic. Depends on ctlru_pkg.
module ctlru_dp #(
   parameter int OFFS_BITS = ctlru_pkg::OFFS_BITS_DEF,
   parameter int SETS = ctlru_pkg::SETS_DEF,
   parameter int WAYS = ctlru_pkg::WAYS_DEF,
   parameter int MAX_ACCESS_BYTES = ctlru_pkg::MAX_ACCESS_BYTES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [ctlru_pkg::ADDR_W-1:0]          req_address,
   input  logic [ctlru_pkg::BC_W-1:0]            req_byte_count,
   input  logic                                  req_is_store,
   input  logic [ctlru_pkg::CYC_W-1:0]           req_cycle_now,
   input  logic [ctlru_pkg::DL_W-1:0]            req_downstream_latency,
   input  logic                                  csr_wr_en,
   input  logic [ctlru_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ctlru_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  ctlru_pkg::cmd_type                    cmd,
   output ctlru_pkg::status_type                 status,
   output logic                                  rsp_valid,
   output logic [ctlru_pkg::LAT_W-1:0]           rsp_latency,
   output logic                                  rsp_was_resident,
   output logic [ctlru_pkg::MISS_W-1:0]          rsp_lines_missed
);

   localparam int LINE_W = ctlru_pkg::ADDR_W - OFFS_BITS;
   localparam int CYC_W = ctlru_pkg::CYC_W;
   localparam int RDY_W = ctlru_pkg::RDY_W;
   localparam int SET_IW = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_IW = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int LINE_BYTES = 1 << OFFS_BITS;
   localparam int MAX_LINES = (LINE_BYTES - 1 + MAX_ACCESS_BYTES - 1) / LINE_BYTES + 1;
   localparam int CNT_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
   localparam int SUM_W = OFFS_BITS + 8;

   // Configuration registers.
   logic [7:0] hit_lat_ff, miss_pen_ff, refill_ff, drain_ff;
   logic [4:0] sb_entries_ff;
   logic       wr_alloc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_lat_ff <= ctlru_pkg::HIT_LATENCY_RST;
         miss_pen_ff <= ctlru_pkg::MISS_PENALTY_RST;
         refill_ff <= ctlru_pkg::REFILL_CYCLES_RST;
         drain_ff <= ctlru_pkg::STORE_DRAIN_RST;
         sb_entries_ff <= ctlru_pkg::SB_ENTRIES_RST;
         wr_alloc_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            ctlru_pkg::CSR_HIT_LATENCY:   hit_lat_ff <= csr_wdata;
            ctlru_pkg::CSR_MISS_PENALTY:  miss_pen_ff <= csr_wdata;
            ctlru_pkg::CSR_REFILL_CYCLES: refill_ff <= csr_wdata;
            ctlru_pkg::CSR_STORE_DRAIN:   drain_ff <= csr_wdata;
            ctlru_pkg::CSR_SB_ENTRIES:    sb_entries_ff <= csr_wdata[4:0];
            ctlru_pkg::CSR_WRITE_ALLOC:   wr_alloc_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Tag array rows, one row per set holding all ways.
   logic [WAYS-1:0]                   valid_mem [SETS];
   logic [WAYS-1:0][LINE_W-1:0]       tag_mem [SETS];
   logic [WAYS-1:0][CYC_W-1:0]        stamp_mem [SETS];
   logic [WAYS-1:0][CYC_W-1:0]        ready_mem [SETS];

   logic [WAYS-1:0]                   rd_valid_ff;
   logic [WAYS-1:0][LINE_W-1:0]       rd_tag_ff;
   logic [WAYS-1:0][CYC_W-1:0]        rd_stamp_ff;
   logic [WAYS-1:0][CYC_W-1:0]        rd_ready_ff;

   logic [WAYS-1:0]                   wr_valid;
   logic [WAYS-1:0][LINE_W-1:0]       wr_tag;
   logic [WAYS-1:0][CYC_W-1:0]        wr_stamp;
   logic [WAYS-1:0][CYC_W-1:0]        wr_ready;

   // Request state.
   logic [LINE_W-1:0]                 first_ff;
   logic [CNT_W-1:0]                  last_k_ff, k_ff;
   logic [CYC_W-1:0]                  now_ff;
   logic [ctlru_pkg::DL_W-1:0]        dl_ff;
   logic                              st_ff;
   logic [RDY_W-1:0]                  ready_ff;
   logic [ctlru_pkg::MISS_W-1:0]      misses_ff;
   logic [CYC_W-1:0]                  use_cnt_ff, port_free_ff;
   logic [CYC_W-1:0]                  start_ff;
   logic                              hit_ff;
   logic [WAY_IW-1:0]                 way_ff, scan_ff;
   logic [11:0]                       slack_ff;
   logic [SET_IW-1:0]                 clr_idx_ff;
   logic                              rsp_valid_ff, rsp_res_ff;
   logic [ctlru_pkg::LAT_W-1:0]       rsp_lat_ff;
   logic [ctlru_pkg::MISS_W-1:0]      rsp_miss_ff;

   logic [6:0]                        size;
   logic [SUM_W-1:0]                  end_sum;
   logic [LINE_W-1:0]                 cur_line;
   logic [SET_IW-1:0]                 set_idx;
   logic [WAYS-1:0]                   hit_vec, inv_vec;
   logic [WAY_IW-1:0]                 hit_way, inv_way;
   logic [CYC_W-1:0]                  start_val, stamp_new, done_sat, refill_sat;
   logic [RDY_W-1:0]                  done_val, refill_end, line_rdy, drain_end;
   logic [RDY_W-1:0]                  lat_diff, slack_ext, pfc_ext;
   logic [4:0]                        entries;

   // Access size and index of the last touched line.
   always_comb begin
      if (req_byte_count == '0) begin
         size = 7'd1;
      end else if (req_byte_count > 7'(MAX_ACCESS_BYTES)) begin
         size = 7'(MAX_ACCESS_BYTES);
      end else begin
         size = req_byte_count;
      end
      end_sum = SUM_W'(req_address[OFFS_BITS-1:0]) + SUM_W'(size) - SUM_W'(1);
   end

   assign cur_line = first_ff + LINE_W'(k_ff);
   assign set_idx = (SETS > 1) ? cur_line[SET_IW-1:0] : '0;

   // Way compare and first invalid way of the row just read.
   always_comb begin
      hit_way = '0;
      inv_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         hit_vec[w] = rd_valid_ff[w] && (rd_tag_ff[w] == cur_line);
         inv_vec[w] = !rd_valid_ff[w];
         if (hit_vec[w]) hit_way = WAY_IW'(w);
         if (inv_vec[w]) inv_way = WAY_IW'(w);
      end
   end

   assign status.clr_last = (clr_idx_ff == SET_IW'(SETS - 1));
   assign status.hit = |hit_vec;
   assign status.alloc = !st_ff || wr_alloc_ff;
   assign status.scan_need = !(|inv_vec) && (WAYS > 1);
   assign status.scan_last = (scan_ff == WAY_IW'(WAYS - 1));
   assign status.line_last = (k_ff == last_k_ff);
   assign status.is_store = st_ff;

   // Refill timing for the current line.
   assign start_val = (now_ff > port_free_ff) ? now_ff : port_free_ff;
   assign done_val = RDY_W'(start_ff) + RDY_W'(dl_ff) + RDY_W'(miss_pen_ff) + RDY_W'(refill_ff);
   assign done_sat = (done_val > RDY_W'(ctlru_pkg::CYC_MAX)) ? ctlru_pkg::CYC_MAX
                                                              : done_val[CYC_W-1:0];
   assign refill_end = RDY_W'(start_ff) + RDY_W'(refill_ff);
   assign refill_sat = (refill_end > RDY_W'(ctlru_pkg::CYC_MAX)) ? ctlru_pkg::CYC_MAX
                                                                  : refill_end[CYC_W-1:0];
   assign stamp_new = use_cnt_ff + CYC_W'(1);
   assign line_rdy = hit_ff ? RDY_W'(rd_ready_ff[way_ff]) : done_val;

   // Updated row for the chosen way.
   always_comb begin
      wr_valid = rd_valid_ff;
      wr_tag = rd_tag_ff;
      wr_stamp = rd_stamp_ff;
      wr_ready = rd_ready_ff;
      wr_valid[way_ff] = 1'b1;
      wr_tag[way_ff] = cur_line;
      wr_stamp[way_ff] = stamp_new;
      if (!hit_ff) wr_ready[way_ff] = done_sat;
   end

   // Store drain and final latency.
   assign entries = (sb_entries_ff > ctlru_pkg::SB_ENTRIES_MAX) ? ctlru_pkg::SB_ENTRIES_MAX
                                                                : sb_entries_ff;
   assign drain_end = RDY_W'(start_val) + RDY_W'(drain_ff);
   assign slack_ext = RDY_W'(slack_ff);
   assign pfc_ext = RDY_W'(port_free_ff);
   assign lat_diff = ready_ff - RDY_W'(now_ff);

   // Valid memory: cleared row by row after reset, then updated per line.
   always_ff @(posedge clock) begin
      if (cmd.clr) begin
         valid_mem[clr_idx_ff] <= '0;
      end else if (cmd.wr) begin
         valid_mem[set_idx] <= wr_valid;
      end
      if (cmd.rd) rd_valid_ff <= valid_mem[set_idx];
   end

   // Tag, stamp and ready memories.
   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         tag_mem[set_idx] <= wr_tag;
         stamp_mem[set_idx] <= wr_stamp;
         ready_mem[set_idx] <= wr_ready;
      end
      if (cmd.rd) begin
         rd_tag_ff <= tag_mem[set_idx];
         rd_stamp_ff <= stamp_mem[set_idx];
         rd_ready_ff <= ready_mem[set_idx];
      end
   end

   // Control-side registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff <= '0;
         use_cnt_ff <= '0;
         port_free_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.out;
         if (cmd.clr) clr_idx_ff <= clr_idx_ff + SET_IW'(1);
         if (cmd.wr) begin
            use_cnt_ff <= stamp_new;
            if (!hit_ff) port_free_ff <= refill_sat;
         end
         if (cmd.st) begin
            port_free_ff <= (drain_end > RDY_W'(ctlru_pkg::CYC_MAX)) ? ctlru_pkg::CYC_MAX
                                                                     : drain_end[CYC_W-1:0];
         end
      end
   end

   // Request payload and per-line working registers.
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         first_ff <= req_address[ctlru_pkg::ADDR_W-1:OFFS_BITS];
         last_k_ff <= CNT_W'(end_sum >> OFFS_BITS);
         k_ff <= '0;
         now_ff <= req_cycle_now;
         dl_ff <= req_downstream_latency;
         st_ff <= req_is_store;
         ready_ff <= RDY_W'(req_cycle_now) + RDY_W'(hit_lat_ff);
         misses_ff <= '0;
      end
      if (cmd.next) k_ff <= k_ff + CNT_W'(1);
      if (cmd.check) begin
         hit_ff <= |hit_vec;
         way_ff <= (|hit_vec) ? hit_way : ((|inv_vec) ? inv_way : '0);
         scan_ff <= WAY_IW'(1);
         start_ff <= start_val;
      end
      // Oldest stamp search, lowest way wins a tie.
      if (cmd.scan) begin
         if (rd_stamp_ff[scan_ff] < rd_stamp_ff[way_ff]) way_ff <= scan_ff;
         scan_ff <= scan_ff + WAY_IW'(1);
      end
      if ((cmd.skip || (cmd.wr && !hit_ff)) && (misses_ff != 2'd3)) begin
         misses_ff <= misses_ff + 2'd1;
      end
      if (cmd.wr && (line_rdy > ready_ff)) ready_ff <= line_rdy;
      if (cmd.st) slack_ff <= 12'(entries) * 12'(drain_ff);
      if (cmd.fin) begin
         if ((pfc_ext > slack_ext) && ((pfc_ext - slack_ext) > ready_ff)) begin
            ready_ff <= pfc_ext - slack_ext;
         end
      end
      if (cmd.out) begin
         rsp_lat_ff <= (lat_diff[RDY_W-1:ctlru_pkg::LAT_W] != '0) ? '1
                                                                  : lat_diff[ctlru_pkg::LAT_W-1:0];
         rsp_res_ff <= (misses_ff == '0);
         rsp_miss_ff <= misses_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_latency = rsp_lat_ff;
   assign rsp_was_resident = rsp_res_ff;
   assign rsp_lines_missed = rsp_miss_ff;

endmodule

>>> hdl/cache_tag_timing_lru.sv
// Top level of the cache tag timing block: controller and datapath.
// Depends on ctlru_pkg, ctlru_ctrl and ctlru_dp.
//
// Usage: a request is taken when start is high and busy is low; it carries
// req_address, req_byte_count, req_is_store, req_cycle_now and
// req_downstream_latency. One response follows per request: rsp_valid is
// high for exactly one cycle with rsp_latency, rsp_was_resident and
// rsp_lines_missed. The receiver cannot stall the response.
// Sequence: each touched line takes a tag row read and a compare step, plus
// an oldest-stamp search over the other ways when a full set must evict,
// plus an update step unless it is a store miss that does not allocate; a
// load then ends with the output step and a store with the drain, finish
// and output steps. A one-line hit load passes the read, compare, update
// and output steps before the strobe, and the next request is taken in the
// strobe cycle.
// Reset: the valid bits live in the row memory, so a clearing pass over all
// SETS rows (64 by default) runs after reset with busy high. Configuration
// writes through csr_wr_en, csr_index and csr_wdata take effect at once and
// are accepted at any time, also during the clearing pass.
module cache_tag_timing_lru #(
   parameter int OFFS_BITS = ctlru_pkg::OFFS_BITS_DEF,
   parameter int SETS = ctlru_pkg::SETS_DEF,
   parameter int WAYS = ctlru_pkg::WAYS_DEF,
   parameter int MAX_ACCESS_BYTES = ctlru_pkg::MAX_ACCESS_BYTES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [ctlru_pkg::ADDR_W-1:0]          req_address,
   input  logic [ctlru_pkg::BC_W-1:0]            req_byte_count,
   input  logic                                  req_is_store,
   input  logic [ctlru_pkg::CYC_W-1:0]           req_cycle_now,
   input  logic [ctlru_pkg::DL_W-1:0]            req_downstream_latency,
   output logic                                  rsp_valid,
   output logic [ctlru_pkg::LAT_W-1:0]           rsp_latency,
   output logic                                  rsp_was_resident,
   output logic [ctlru_pkg::MISS_W-1:0]          rsp_lines_missed,
   input  logic                                  csr_wr_en,
   input  logic [ctlru_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ctlru_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   ctlru_pkg::cmd_type    cmd;
   ctlru_pkg::status_type status;

   // Sequencer.
   ctlru_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // Tag arrays and arithmetic.
   ctlru_dp #(
      .OFFS_BITS        (OFFS_BITS),
      .SETS             (SETS),
      .WAYS             (WAYS),
      .MAX_ACCESS_BYTES (MAX_ACCESS_BYTES)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .req_address            (req_address),
      .req_byte_count         (req_byte_count),
      .req_is_store           (req_is_store),
      .req_cycle_now          (req_cycle_now),
      .req_downstream_latency (req_downstream_latency),
      .csr_wr_en              (csr_wr_en),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .cmd                    (cmd),
      .status                 (status),
      .rsp_valid              (rsp_valid),
      .rsp_latency            (rsp_latency),
      .rsp_was_resident       (rsp_was_resident),
      .rsp_lines_missed       (rsp_lines_missed)
   );

`ifndef SYNTH
   // An accepted request keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   // Responses never come in two adjacent cycles.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   // Residency and miss count agree.
   a_resident_misses: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_was_resident == (rsp_lines_missed == 2'd0)))
      else $error("resident flag disagrees with miss count");

   // A response appears only once the block has finished the request.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without a request in flight");
`endif

endmodule
